// ===== rtl/core/esparw_pkg.sv =====
package esparw_pkg;

   localparam int SEQ_W = 32;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_ESN_ENABLE    = 1'b0,
      CSR_REPLAY_ENABLE = 1'b1
   } csr_index_type;

   // verdict for one sequence number against the current window
   typedef struct packed {
      logic             replay;
      logic [SEQ_W-1:0] seq_high;
      logic             slide;     // move top of window to this number
      logic             mark;      // set the bit of this number
      logic             high_we;   // take the next high word
   } decision_type;

endpackage

// ===== rtl/core/esparw_decide.sv =====
module esparw_decide #(
   parameter int WINDOW_BITS = 64
) (
   input  logic [esparw_pkg::SEQ_W-1:0] seq,
   input  logic [esparw_pkg::SEQ_W-1:0] top_seq,
   input  logic [esparw_pkg::SEQ_W-1:0] top_high,
   input  logic [WINDOW_BITS-1:0]       bitmap,
   input  logic                         esn_enable,
   input  logic                         replay_enable,
   output esparw_pkg::decision_type     dec,
   output logic [WINDOW_BITS-1:0]       bitmap_nxt
);
   import esparw_pkg::*;

   localparam int IW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
   localparam logic [SEQ_W-1:0] WIN = SEQ_W'(WINDOW_BITS);
   localparam logic [WINDOW_BITS-1:0] ONE = WINDOW_BITS'(1);

   logic [SEQ_W-1:0] back;
   logic [SEQ_W-1:0] fwd_dist;
   logic [SEQ_W-1:0] low_edge;
   logic             back_in;
   logic             fwd_in;
   logic             seen;
   logic             seq_gt;
   logic             seq_ge_low;
   logic             full_window;

   assign back        = top_seq - seq;
   assign fwd_dist    = seq - top_seq;
   assign low_edge    = top_seq - WIN + SEQ_W'(1);
   assign back_in     = back < WIN;
   assign fwd_in      = fwd_dist < WIN;
   // anything behind the window counts as seen
   assign seen        = !back_in || bitmap[back[IW-1:0]];
   assign seq_gt      = seq > top_seq;
   assign seq_ge_low  = seq >= low_edge;
   assign full_window = top_seq >= (WIN - SEQ_W'(1));

   always_comb begin
      dec          = '0;
      dec.seq_high = top_high;
      if (replay_enable) begin
         if (!esn_enable) begin
            if (seq_gt) begin
               dec.slide = 1'b1;
            end else if (seen) begin
               dec.replay = 1'b1;
            end else begin
               dec.mark = 1'b1;
            end
         end else if (full_window) begin
            if (seq_ge_low) begin
               if (seq_gt) begin
                  dec.slide = 1'b1;
               end else if (seen) begin
                  dec.replay = 1'b1;
               end else begin
                  dec.mark = 1'b1;
               end
            end else begin
               // number wrapped into the next high word
               dec.seq_high = top_high + SEQ_W'(1);
               dec.slide    = 1'b1;
               dec.high_we  = 1'b1;
            end
         end else begin
            if (seq_ge_low) begin
               // number belongs to the previous high word
               dec.seq_high = top_high - SEQ_W'(1);
               if (seen) begin
                  dec.replay = 1'b1;
               end else begin
                  dec.mark = 1'b1;
               end
            end else if (!seq_gt) begin
               if (seen) begin
                  dec.replay = 1'b1;
               end else begin
                  dec.mark = 1'b1;
               end
            end else begin
               dec.slide = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (dec.slide) begin
         bitmap_nxt = fwd_in ? ((bitmap << fwd_dist[IW-1:0]) | ONE) : ONE;
      end else if (dec.mark && back_in) begin
         bitmap_nxt = bitmap | (ONE << back[IW-1:0]);
      end else begin
         bitmap_nxt = bitmap;
      end
   end

endmodule

// ===== rtl/core/esp_anti_replay_window_unit.sv =====
// Channel | Dir | Payload (low bit first)          | Handshake
// req     | in  | tdata: seq_low[31:0]             | req_tvalid / req_tready
// rsp     | out | tdata: seq_high[31:0]; tuser: replay | rsp_tvalid / rsp_tready
// csr     | in  | wdata[0] to register csr_index   | csr_we, no wait
//
// One item per cycle while rsp is not stalled; an accepted item goes through the input
// register, then the window check and update into the result register, then shows on rsp.
// The window state is updated in the same cycle the result register loads, so
// the next item always sees the state left by the one before it.
// Reset is synchronous: window cleared, esn_enable = 0, replay_enable = 1.
// A stalled rsp holds the result register; req keeps accepting while the
// input register is empty or moving on.
module esp_anti_replay_window_unit #(
   parameter int WINDOW_BITS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [esparw_pkg::SEQ_W-1:0]       req_tdata,   // seq_low[31:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [esparw_pkg::SEQ_W-1:0]       rsp_tdata,   // seq_high[31:0]
   output logic                               rsp_tuser,   // replay
   input  logic                               csr_we,
   input  esparw_pkg::csr_index_type          csr_index,
   input  logic                               csr_wdata
);
   import esparw_pkg::*;

   logic                   esn_ff, esn_in;
   logic                   rpl_ff, rpl_in;
   logic                   in_valid_ff, in_valid_in;
   logic [SEQ_W-1:0]       in_seq_ff, in_seq_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_replay_ff, rsp_replay_in;
   logic [SEQ_W-1:0]       rsp_high_ff, rsp_high_in;
   logic [SEQ_W-1:0]       top_seq_ff, top_seq_in;
   logic [SEQ_W-1:0]       top_high_ff, top_high_in;
   logic [WINDOW_BITS-1:0] bitmap_ff, bitmap_in;

   decision_type           dec;
   logic [WINDOW_BITS-1:0] bitmap_nxt;
   logic                   req_fire;
   logic                   check_fire;

   esparw_decide #(
      .WINDOW_BITS(WINDOW_BITS)
   ) u_decide (
      .seq          (in_seq_ff),
      .top_seq      (top_seq_ff),
      .top_high     (top_high_ff),
      .bitmap       (bitmap_ff),
      .esn_enable   (esn_ff),
      .replay_enable(rpl_ff),
      .dec          (dec),
      .bitmap_nxt   (bitmap_nxt)
   );

   assign check_fire = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || check_fire;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_high_ff;
   assign rsp_tuser  = rsp_replay_ff;

   always_comb begin
      esn_in = esn_ff;
      rpl_in = rpl_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ESN_ENABLE:    esn_in = csr_wdata;
            CSR_REPLAY_ENABLE: rpl_in = csr_wdata;
            default:           ;
         endcase
      end
   end

   always_comb begin
      in_valid_in   = req_fire ? 1'b1 : (check_fire ? 1'b0 : in_valid_ff);
      in_seq_in     = req_fire ? req_tdata : in_seq_ff;
      rsp_valid_in  = check_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_replay_in = check_fire ? dec.replay : rsp_replay_ff;
      rsp_high_in   = check_fire ? dec.seq_high : rsp_high_ff;
      top_seq_in    = (check_fire && dec.slide) ? in_seq_ff : top_seq_ff;
      top_high_in   = (check_fire && dec.high_we) ? dec.seq_high : top_high_ff;
      bitmap_in     = check_fire ? bitmap_nxt : bitmap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esn_ff       <= 1'b0;
         rpl_ff       <= 1'b1;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         top_seq_ff   <= '0;
         top_high_ff  <= '0;
         bitmap_ff    <= '0;
      end else begin
         esn_ff       <= esn_in;
         rpl_ff       <= rpl_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         top_seq_ff   <= top_seq_in;
         top_high_ff  <= top_high_in;
         bitmap_ff    <= bitmap_in;
      end
   end

   always_ff @(posedge clock) begin
      in_seq_ff     <= in_seq_in;
      rsp_replay_ff <= rsp_replay_in;
      rsp_high_ff   <= rsp_high_in;
   end

   // a replay leaves the window untouched
   assert property (@(posedge clock) disable iff (reset)
      (check_fire && dec.replay) |=> ($stable(bitmap_ff) && $stable(top_seq_ff)))
      else $error("window changed on a replayed item");

   // a slide always marks the new top
   assert property (@(posedge clock) disable iff (reset)
      (check_fire && dec.slide) |=> bitmap_ff[0])
      else $error("slide did not mark the new top");

   // high word moves only on a wrap into the next high word
   assert property (@(posedge clock) disable iff (reset)
      !(check_fire && dec.high_we) |=> $stable(top_high_ff))
      else $error("high word changed without a wrap");

   // a mark leaves at least one bit set
   assert property (@(posedge clock) disable iff (reset)
      (check_fire && dec.mark) |=> (bitmap_ff != '0))
      else $error("mark left an empty window");

   // full input register behind a stalled result takes nothing
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("item accepted while pipeline stalled");

endmodule
